// ===== design/crcdfr_pkg.sv =====
`timescale 1ns / 1ps

package crcdfr_pkg;

   // Frame buffer geometry
   localparam int FRAME_BUF_BYTES      = 64;
   localparam int FRAME_OVERHEAD_BYTES = 7;
   localparam int MAX_LEN              = FRAME_BUF_BYTES - FRAME_OVERHEAD_BYTES;
   localparam int LEN_W                = 6;
   localparam int IDX_W                = $clog2(FRAME_BUF_BYTES);
   localparam int BANKS                = 2;
   localparam int MEM_DEPTH            = BANKS * FRAME_BUF_BYTES;
   localparam int MEM_AW               = IDX_W + 1;

   // CRC-16/Modbus
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Register map
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_HEAD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_HEAD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAIL        = 2'd2;

   localparam logic [7:0] RST_FIRST_HEAD  = 8'hA5;
   localparam logic [7:0] RST_SECOND_HEAD = 8'h5A;
   localparam logic [7:0] RST_TAIL        = 8'hFF;

   // One completed frame handed from parser to replay
   typedef struct packed {
      logic [7:0]       command;
      logic [LEN_W-1:0] length;
      logic             bank;
   } frame_desc_type;

   // Payload buffer write port
   typedef struct packed {
      logic              en;
      logic [MEM_AW-1:0] addr;
      logic [7:0]        data;
   } buf_wr_type;

   // Fold one byte into the running CRC, LSB first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== design/crcdfr_req_if.sv =====
`timescale 1ns / 1ps

interface crcdfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== design/crcdfr_rsp_if.sv =====
`timescale 1ns / 1ps

interface crcdfr_rsp_if import crcdfr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [7:0]       command;
   logic [LEN_W-1:0] payload_length;
   logic [7:0]       data_byte;
   logic             data_valid;
   logic             last;

   modport source (output valid, output command, output payload_length, output data_byte,
                   output data_valid, output last, input ready);
   modport sink   (input valid, input command, input payload_length, input data_byte,
                   input data_valid, input last, output ready);
endinterface

// ===== design/crc16_command_frame_deframer.sv =====
`timescale 1ns / 1ps

// Receives a byte stream on req, one byte per transfer, and finds frames of
// the form head1 head2 LEN CMD payload CRC_hi CRC_lo tail, checked by
// CRC-16/Modbus over head1 to the last payload byte. Head and tail bytes are
// set through the csr port (index 0 first head, 1 second head, 2 tail). Each
// good frame is replayed on rsp as one result per payload byte, or a single
// result with data_valid low when LEN is zero; bad frames give nothing. The
// parser takes one byte per cycle. Payload lands in a two-bank buffer, so up
// to two completed frames can wait for replay; while both banks are held the
// parser stops taking bytes. Replay issues each registered buffer read only after
// the previous byte has been loaded into the output register.
module crc16_command_frame_deframer import crcdfr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   crcdfr_req_if.sink           req,
   crcdfr_rsp_if.source         rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   logic           q_full;
   logic           q_empty;
   logic           push;
   logic           pop;
   logic           back_busy;
   frame_desc_type push_desc;
   frame_desc_type q_head;
   buf_wr_type     buf_wr;

   crcdfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .push      (push),
      .push_desc (push_desc),
      .buf_wr    (buf_wr)
   );

   crcdfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .back_busy (back_busy),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   crcdfr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .buf_wr  (buf_wr),
      .q_empty (q_empty),
      .q_head  (q_head),
      .pop     (pop),
      .busy    (back_busy),
      .rsp     (rsp)
   );

endmodule

// ===== design/crcdfr_front.sv =====
`timescale 1ns / 1ps

module crcdfr_front import crcdfr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   crcdfr_req_if.sink           req,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata,
   input  logic                 q_full,
   output logic                 push,
   output frame_desc_type       push_desc,
   output buf_wr_type           buf_wr
);

   localparam logic [2:0] ST_HEAD1   = 3'd0;
   localparam logic [2:0] ST_HEAD2   = 3'd1;
   localparam logic [2:0] ST_LEN     = 3'd2;
   localparam logic [2:0] ST_CMD     = 3'd3;
   localparam logic [2:0] ST_PAYLOAD = 3'd4;
   localparam logic [2:0] ST_CRC_HI  = 3'd5;
   localparam logic [2:0] ST_CRC_LO  = 3'd6;
   localparam logic [2:0] ST_TAIL    = 3'd7;

   logic [7:0]       head1_ff, head2_ff, tail_ff;
   logic [2:0]       step_ff, step_in;
   logic [15:0]      crc_ff, crc_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [7:0]       crc_hi_ff, crc_hi_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             bank_ff, bank_in;
   logic             take;
   logic [7:0]       b;
   logic [15:0]      crc_next;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head1_ff <= RST_FIRST_HEAD;
         head2_ff <= RST_SECOND_HEAD;
         tail_ff  <= RST_TAIL;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIRST_HEAD:  head1_ff <= csr_wdata;
            CSR_SECOND_HEAD: head2_ff <= csr_wdata;
            CSR_TAIL:        tail_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Hold input while both buffer banks are taken
   assign req.ready = !q_full;
   assign take      = req.valid && req.ready;
   assign b         = req.rx_byte;
   assign crc_next  = crc_feed(crc_ff, b);

   assign push_desc.command = cmd_ff;
   assign push_desc.length  = len_ff;
   assign push_desc.bank    = bank_ff;

   // Parse one byte per transfer
   always_comb begin
      step_in   = step_ff;
      crc_in    = crc_ff;
      len_in    = len_ff;
      cmd_in    = cmd_ff;
      crc_hi_in = crc_hi_ff;
      idx_in    = idx_ff;
      bank_in   = bank_ff;
      push      = 1'b0;
      buf_wr    = '0;
      if (take) begin
         case (step_ff)
            ST_HEAD1: begin
               if (b == head1_ff) begin
                  step_in = ST_HEAD2;
                  crc_in  = crc_feed(CRC_INIT, b);
               end
            end
            ST_HEAD2: begin
               if (b == head2_ff) begin
                  crc_in  = crc_next;
                  step_in = ST_LEN;
               end else if (b == head1_ff) begin
                  step_in = ST_HEAD2;
                  crc_in  = crc_feed(CRC_INIT, b);
               end else begin
                  step_in = ST_HEAD1;
                  crc_in  = CRC_INIT;
               end
            end
            ST_LEN: begin
               // Drop frames whose payload cannot fit the buffer
               if (b > 8'(MAX_LEN)) begin
                  step_in = ST_HEAD1;
                  crc_in  = CRC_INIT;
               end else begin
                  len_in  = b[LEN_W-1:0];
                  crc_in  = crc_next;
                  step_in = ST_CMD;
               end
            end
            ST_CMD: begin
               cmd_in  = b;
               crc_in  = crc_next;
               idx_in  = '0;
               step_in = (len_ff == '0) ? ST_CRC_HI : ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
               buf_wr.en   = 1'b1;
               buf_wr.addr = {bank_ff, idx_ff};
               buf_wr.data = b;
               crc_in      = crc_next;
               idx_in      = idx_ff + 1'b1;
               if (({1'b0, idx_ff} + 7'd1) >= {1'b0, len_ff}) begin
                  step_in = ST_CRC_HI;
               end
            end
            ST_CRC_HI: begin
               crc_hi_in = b;
               step_in   = ST_CRC_LO;
            end
            ST_CRC_LO: begin
               if ({crc_hi_ff, b} == crc_ff) begin
                  step_in = ST_TAIL;
               end else if (b == head1_ff) begin
                  step_in = ST_HEAD2;
                  crc_in  = crc_feed(CRC_INIT, b);
               end else begin
                  step_in = ST_HEAD1;
                  crc_in  = CRC_INIT;
               end
            end
            ST_TAIL: begin
               if (b == tail_ff) begin
                  // Hand the frame to replay and flip to the other bank
                  push    = 1'b1;
                  bank_in = !bank_ff;
                  step_in = ST_HEAD1;
                  crc_in  = CRC_INIT;
               end else if (b == head1_ff) begin
                  step_in = ST_HEAD2;
                  crc_in  = crc_feed(CRC_INIT, b);
               end else begin
                  step_in = ST_HEAD1;
                  crc_in  = CRC_INIT;
               end
            end
            default: begin
               step_in = ST_HEAD1;
               crc_in  = CRC_INIT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_HEAD1;
         crc_ff  <= CRC_INIT;
         bank_ff <= 1'b0;
         idx_ff  <= '0;
         len_ff  <= '0;
      end else begin
         step_ff <= step_in;
         crc_ff  <= crc_in;
         bank_ff <= bank_in;
         idx_ff  <= idx_in;
         len_ff  <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      crc_hi_ff <= crc_hi_in;
   end

endmodule

// ===== design/crcdfr_queue.sv =====
`timescale 1ns / 1ps

module crcdfr_queue import crcdfr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  frame_desc_type push_desc,
   input  logic           pop,
   input  logic           back_busy,
   output logic           full,
   output logic           empty,
   output frame_desc_type head
);

   frame_desc_type q_ff [BANKS];
   logic           wr_ptr_ff, rd_ptr_ff;
   logic [1:0]     count_ff;
   logic [1:0]     in_use;

   // A bank stays taken until the replay of its frame is over
   assign in_use = count_ff + {1'b0, back_busy};
   assign full   = in_use >= 2'd2;
   assign empty  = count_ff == 2'd0;
   assign head   = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_desc;
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   a_push_room: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("frame pushed while both banks are taken");
   a_pop_data: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("frame popped from an empty queue");

endmodule

// ===== design/crcdfr_back.sv =====
`timescale 1ns / 1ps

module crcdfr_back import crcdfr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  buf_wr_type     buf_wr,
   input  logic           q_empty,
   input  frame_desc_type q_head,
   output logic           pop,
   output logic           busy,
   crcdfr_rsp_if.source   rsp
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic [7:0]       mem [MEM_DEPTH];
   logic [7:0]       rdata_ff;
   logic             state_ff;
   frame_desc_type   desc_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             rd_pend_ff;
   logic             out_valid_ff;
   logic [7:0]       out_cmd_ff;
   logic [LEN_W-1:0] out_len_ff;
   logic [7:0]       out_data_ff;
   logic             out_dv_ff;
   logic             out_last_ff;
   logic             slot_free;
   logic             all_issued;
   logic             rd_en;
   logic             load_data;
   logic             load_empty;

   // Payload buffer, two banks
   always_ff @(posedge clock) begin
      if (buf_wr.en) begin
         mem[buf_wr.addr] <= buf_wr.data;
      end
      if (rd_en) begin
         rdata_ff <= mem[{desc_ff.bank, idx_ff}];
      end
   end

   assign slot_free  = !out_valid_ff || rsp.ready;
   assign all_issued = {1'b0, idx_ff} == {1'b0, desc_ff.length};
   assign pop        = (state_ff == ST_IDLE) && !q_empty;
   assign busy       = state_ff == ST_RUN;
   assign rd_en      = (state_ff == ST_RUN) && (desc_ff.length != '0) && !rd_pend_ff
                       && !all_issued && slot_free;
   assign load_data  = rd_pend_ff && slot_free;
   assign load_empty = (state_ff == ST_RUN) && (desc_ff.length == '0) && slot_free;

   // Sequence the replay
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_pend_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  state_ff <= ST_RUN;
                  idx_ff   <= '0;
               end
            end
            ST_RUN: begin
               if (load_empty || (load_data && all_issued)) begin
                  state_ff <= ST_IDLE;
               end
               if (rd_en) begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (rd_en) begin
            rd_pend_ff <= 1'b1;
         end else if (load_data) begin
            rd_pend_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         desc_ff <= q_head;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_data || load_empty) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_data || load_empty) begin
         out_cmd_ff  <= desc_ff.command;
         out_len_ff  <= desc_ff.length;
         out_data_ff <= load_data ? rdata_ff : 8'h00;
         out_dv_ff   <= load_data;
         out_last_ff <= load_empty || all_issued;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.command        = out_cmd_ff;
   assign rsp.payload_length = out_len_ff;
   assign rsp.data_byte      = out_data_ff;
   assign rsp.data_valid     = out_dv_ff;
   assign rsp.last           = out_last_ff;

   a_pend_origin: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> ($past(rd_en) || $past(rd_pend_ff)))
      else $error("buffer read pending without an issued read");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> ({1'b0, idx_ff} <= {1'b0, desc_ff.length}))
      else $error("replay index ran past the frame length");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import crcdfr_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_TICKS = 16;

   typedef enum logic [2:0] {
      PS_HEAD1, PS_HEAD2, PS_LEN, PS_CMD, PS_PAYLOAD, PS_CRC_HI, PS_CRC_LO, PS_TAIL
   } parse_step_type;

   typedef enum int {
      FK_GOOD, FK_BAD_CRC, FK_CRC_RESTART, FK_BAD_TAIL, FK_TAIL_RESTART, FK_BAD_HEAD2,
      FK_LONG_LEN
   } frame_kind_type;

   typedef struct packed {
      logic [7:0]       command;
      logic [LEN_W-1:0] payload_length;
      logic [7:0]       data_byte;
      logic             data_valid;
      logic             last;
   } frame_result_type;

   // Frame parser mirror and the replay results it still owes
   class frame_scoreboard;
      logic [7:0]       head1, head2, tail;
      parse_step_type   step;
      logic [6:0]       count;
      logic [7:0]       frame_len, frame_cmd;
      logic [15:0]      crc_seen, crc_acc;
      logic [7:0]       payload [FRAME_BUF_BYTES];
      frame_result_type replay_q[$];
      int               errors;

      function new();
         head1  = RST_FIRST_HEAD;
         head2  = RST_SECOND_HEAD;
         tail   = RST_TAIL;
         errors = 0;
         drop_frame();
      endfunction

      // CRC-16/Modbus, one input bit at a time, LSB first
      static function logic [15:0] crc16_fold(logic [15:0] acc, logic [7:0] b);
         logic fb;
         for (int i = 0; i < 8; i++) begin
            fb  = acc[0] ^ b[i];
            acc = acc >> 1;
            if (fb) acc = acc ^ 16'hA001;
         end
         return acc;
      endfunction

      function void report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [7:0] val);
         case (idx)
            CSR_FIRST_HEAD:  head1 = val;
            CSR_SECOND_HEAD: head2 = val;
            CSR_TAIL:        tail  = val;
            default: ;
         endcase
      endfunction

      function void drop_frame();
         step      = PS_HEAD1;
         count     = '0;
         frame_len = '0;
         frame_cmd = '0;
         crc_seen  = '0;
         crc_acc   = 16'hFFFF;
      endfunction

      function void open_frame();
         drop_frame();
         step    = PS_HEAD2;
         count   = 7'd1;
         crc_acc = crc16_fold(16'hFFFF, head1);
      endfunction

      function void absorb(logic [7:0] b);
         crc_acc = crc16_fold(crc_acc, b);
         count   = count + 7'd1;
      endfunction

      // Queue the replay of a frame closed by a good tail
      function void replay_frame();
         frame_result_type r;
         if (frame_len == 0) begin
            r = '{command: frame_cmd, payload_length: '0, data_byte: '0,
                  data_valid: 1'b0, last: 1'b1};
            replay_q.push_back(r);
         end else begin
            for (int i = 0; i < int'(frame_len); i++) begin
               r.command        = frame_cmd;
               r.payload_length = frame_len[LEN_W-1:0];
               r.data_byte      = payload[i];
               r.data_valid     = 1'b1;
               r.last           = (i == int'(frame_len) - 1);
               replay_q.push_back(r);
            end
         end
      endfunction

      // Advance the parser by one accepted byte
      function void note_byte(logic [7:0] b);
         int idx;
         case (step)
            PS_HEAD1: if (b == head1) open_frame();
            PS_HEAD2: begin
               if (b == head2) begin
                  absorb(b);
                  step = PS_LEN;
               end else if (b == head1) begin
                  open_frame();
               end else begin
                  drop_frame();
               end
            end
            PS_LEN: begin
               if (int'(b) > MAX_LEN) begin
                  drop_frame();
               end else begin
                  frame_len = b;
                  absorb(b);
                  step = PS_CMD;
               end
            end
            PS_CMD: begin
               absorb(b);
               frame_cmd = b;
               step = (frame_len == 0) ? PS_CRC_HI : PS_PAYLOAD;
            end
            PS_PAYLOAD: begin
               idx = int'(count) - 4;
               payload[idx] = b;
               absorb(b);
               if (idx + 1 >= int'(frame_len)) step = PS_CRC_HI;
            end
            PS_CRC_HI: begin
               crc_seen = {b, 8'h00};
               step = PS_CRC_LO;
            end
            PS_CRC_LO: begin
               crc_seen[7:0] = b;
               if (crc_seen == crc_acc) step = PS_TAIL;
               else if (b == head1) open_frame();
               else drop_frame();
            end
            PS_TAIL: begin
               if (b == tail) begin
                  replay_frame();
                  drop_frame();
               end else if (b == head1) begin
                  open_frame();
               end else begin
                  drop_frame();
               end
            end
            default: drop_frame();
         endcase
      endfunction

      // Compare one transfer on the result channel with the oldest owed result
      function void check_result(frame_result_type got);
         frame_result_type want;
         if (replay_q.size() == 0) begin
            report($sformatf("unexpected result cmd %02h len %0d data %02h dv %0b last %0b",
                             got.command, got.payload_length, got.data_byte,
                             got.data_valid, got.last));
            return;
         end
         want = replay_q.pop_front();
         if (got.command !== want.command)
            report($sformatf("command %02h, want %02h", got.command, want.command));
         if (got.payload_length !== want.payload_length)
            report($sformatf("payload_length %0d, want %0d",
                             got.payload_length, want.payload_length));
         if (got.data_byte !== want.data_byte)
            report($sformatf("data_byte %02h, want %02h", got.data_byte, want.data_byte));
         if (got.data_valid !== want.data_valid)
            report($sformatf("data_valid %0b, want %0b", got.data_valid, want.data_valid));
         if (got.last !== want.last)
            report($sformatf("last %0b, want %0b", got.last, want.last));
      endfunction
   endclass

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FIRST_HEAD;
   logic [7:0]           csr_wdata = 8'h00;

   crcdfr_req_if req_ch ();
   crcdfr_rsp_if rsp_ch ();

   frame_scoreboard sb;
   logic [7:0]      link_bytes[$];
   bit              no_idle = 1'b0;
   int              bytes_sent = 0;
   int unsigned     cycles = 0;

   crc16_command_frame_deframer dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Result channel: hold ready low for a random stall before each transfer, none while no_idle is set
   initial begin : rsp_stall
      int stall;
      rsp_ch.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(negedge clock); while (!rsp_ch.valid);
         @(posedge clock);
      end
   end

   // Check every result transfer, sampled mid-cycle ahead of its edge
   always @(negedge clock) begin : rsp_monitor
      frame_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.command        = rsp_ch.command;
         got.payload_length = rsp_ch.payload_length;
         got.data_byte      = rsp_ch.data_byte;
         got.data_valid     = rsp_ch.data_valid;
         got.last           = rsp_ch.last;
         sb.check_result(got);
      end
   end

   // Offer one byte after a random gap, none while no_idle is set, and hold it until the transfer
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(negedge clock); while (!req_ch.ready);
      @(posedge clock);
      sb.note_byte(b);
      bytes_sent++;
   endtask

   task automatic flush_link();
      while (link_bytes.size() > 0) send_byte(link_bytes.pop_front());
   endtask

   task automatic idle_link();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (sb.replay_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   // Reprogram the sync and tail bytes once the block has gone quiet
   task automatic set_regs(input logic [7:0] h1, input logic [7:0] h2, input logic [7:0] t);
      idle_link();
      wait_drained();
      repeat (SETTLE_TICKS) @(posedge clock);
      write_reg(CSR_FIRST_HEAD, h1);
      write_reg(CSR_SECOND_HEAD, h2);
      write_reg(CSR_TAIL, t);
      csr_we <= 1'b0;
   endtask

   // Mostly short payloads, now and then up to the buffer limit
   function automatic int rand_len();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return MAX_LEN;
      if (r < 3) return $urandom_range(9, MAX_LEN);
      return $urandom_range(0, 8);
   endfunction

   // Append one frame, damaged as the kind says; skip_head1 continues a restart
   task automatic add_frame(input frame_kind_type kind, input int len, input logic [7:0] cmd,
                            input bit skip_head1);
      logic [15:0] crc;
      logic [7:0]  hi, lo, t, pb;
      if (!skip_head1) link_bytes.push_back(sb.head1);
      crc = frame_scoreboard::crc16_fold(16'hFFFF, sb.head1);
      if (kind == FK_BAD_HEAD2) begin
         link_bytes.push_back(sb.head2 ^ 8'($urandom_range(1, 255)));
         return;
      end
      link_bytes.push_back(sb.head2);
      crc = frame_scoreboard::crc16_fold(crc, sb.head2);
      link_bytes.push_back(8'(len));
      if (kind == FK_LONG_LEN) return;
      crc = frame_scoreboard::crc16_fold(crc, 8'(len));
      link_bytes.push_back(cmd);
      crc = frame_scoreboard::crc16_fold(crc, cmd);
      for (int i = 0; i < len; i++) begin
         pb = 8'($urandom_range(0, 255));
         link_bytes.push_back(pb);
         crc = frame_scoreboard::crc16_fold(crc, pb);
      end
      {hi, lo} = crc;
      if (kind == FK_BAD_CRC) begin
         {hi, lo} = crc ^ (16'h0001 << $urandom_range(0, 15));
      end else if (kind == FK_CRC_RESTART) begin
         lo = sb.head1;
         if ({hi, lo} == crc) hi = hi ^ 8'h80;
      end
      link_bytes.push_back(hi);
      link_bytes.push_back(lo);
      if (kind == FK_CRC_RESTART) return;
      t = sb.tail;
      if (kind == FK_BAD_TAIL) t = sb.tail ^ 8'($urandom_range(1, 255));
      else if (kind == FK_TAIL_RESTART) t = sb.head1;
      link_bytes.push_back(t);
   endtask

   // Random traffic: mostly well-formed frames, the rest damaged frames and noise
   task automatic run_random(input int n_bytes);
      int target;
      int pick;
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) begin
         if ($urandom_range(0, 9) == 0) no_idle = !no_idle;
         pick = $urandom_range(0, 99);
         if (pick < 62) begin
            add_frame(FK_GOOD, rand_len(), 8'($urandom), 1'b0);
         end else if (pick < 69) begin
            add_frame(FK_BAD_CRC, rand_len(), 8'($urandom), 1'b0);
         end else if (pick < 74) begin
            add_frame(FK_CRC_RESTART, rand_len(), 8'($urandom), 1'b0);
            add_frame(FK_GOOD, rand_len(), 8'($urandom), 1'b1);
         end else if (pick < 80) begin
            add_frame(FK_BAD_TAIL, rand_len(), 8'($urandom), 1'b0);
         end else if (pick < 84) begin
            add_frame(FK_TAIL_RESTART, rand_len(), 8'($urandom), 1'b0);
            add_frame(FK_GOOD, rand_len(), 8'($urandom), 1'b1);
         end else if (pick < 89) begin
            link_bytes.push_back(sb.head1);
            add_frame(FK_GOOD, rand_len(), 8'($urandom), 1'b0);
         end else if (pick < 92) begin
            add_frame(FK_BAD_HEAD2, 0, 8'h00, 1'b0);
         end else if (pick < 95) begin
            add_frame(FK_LONG_LEN, $urandom_range(MAX_LEN + 1, 255), 8'h00, 1'b0);
         end else begin
            repeat ($urandom_range(1, 6)) link_bytes.push_back(8'($urandom));
         end
         flush_link();
      end
   endtask

   initial begin : stimulus
      sb = new();
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, empty and full frames, every drop and restart path
      link_bytes.push_back(8'h00);
      link_bytes.push_back(8'hFF);
      add_frame(FK_GOOD, 0, 8'h00, 1'b0);
      add_frame(FK_GOOD, 1, 8'hFF, 1'b0);
      add_frame(FK_GOOD, MAX_LEN, 8'h5C, 1'b0);
      add_frame(FK_LONG_LEN, MAX_LEN + 1, 8'h00, 1'b0);
      add_frame(FK_LONG_LEN, 255, 8'h00, 1'b0);
      link_bytes.push_back(sb.head1);
      add_frame(FK_GOOD, 2, 8'h11, 1'b0);
      add_frame(FK_BAD_HEAD2, 0, 8'h00, 1'b0);
      add_frame(FK_BAD_CRC, 3, 8'h22, 1'b0);
      add_frame(FK_CRC_RESTART, 2, 8'h33, 1'b0);
      add_frame(FK_GOOD, 1, 8'h44, 1'b1);
      add_frame(FK_BAD_TAIL, 1, 8'h55, 1'b0);
      add_frame(FK_TAIL_RESTART, 4, 8'h66, 1'b0);
      add_frame(FK_GOOD, 0, 8'h77, 1'b1);
      flush_link();

      // Hold the sender until every owed result is out
      idle_link();
      wait_drained();

      // Back-to-back frames to fill both replay banks
      no_idle = 1'b1;
      repeat (6) add_frame(FK_GOOD, rand_len(), 8'($urandom), 1'b0);
      flush_link();
      no_idle = 1'b0;
      run_random(20);

      // Extreme and degenerate register settings, then random ones, then the reset values
      set_regs(8'h00, 8'hFF, 8'h00);
      run_random(50);
      set_regs(8'hFF, 8'h00, 8'hFF);
      run_random(50);
      set_regs(8'h3C, 8'h3C, 8'h3C);
      run_random(40);
      set_regs(8'($urandom), 8'($urandom), 8'($urandom));
      run_random(40);
      set_regs(RST_FIRST_HEAD, RST_SECOND_HEAD, RST_TAIL);
      run_random(40);

      // Drain and let any stray result show up
      idle_link();
      wait_drained();
      repeat (40) @(posedge clock);
      if (sb.errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
